// ===== design/atce_pkg.sv =====
// ----------------------------------------------------------------------------
// atce_pkg: shared types and constants of the ANSI text console engine
// Screen geometry, character codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package atce_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 30;
	localparam int MAX_PARAMS = 8;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int PIDX_W = 3;
	localparam int CLR_W  = 4;
	localparam int CH_W   = 8;

	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_BS    = 8'h08;
	localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [CH_W-1:0] CH_LBRK  = 8'h5B;
	localparam logic [CH_W-1:0] CH_SGR   = 8'h6D;
	localparam logic [CH_W-1:0] CH_CUP_H = 8'h48;
	localparam logic [CH_W-1:0] CH_CUP_F = 8'h66;
	localparam logic [CH_W-1:0] CH_CUU   = 8'h41;
	localparam logic [CH_W-1:0] CH_CUD   = 8'h42;
	localparam logic [CH_W-1:0] CH_CUF   = 8'h43;
	localparam logic [CH_W-1:0] CH_CUB   = 8'h44;
	localparam logic [CH_W-1:0] CH_CHA   = 8'h47;

	localparam logic [7:0] SGR_RESET  = 8'd0;
	localparam logic [7:0] SGR_FG_LO  = 8'd30;
	localparam logic [7:0] SGR_FG_HI  = 8'd37;
	localparam logic [7:0] SGR_FG_DEF = 8'd39;
	localparam logic [7:0] SGR_BG_LO  = 8'd40;
	localparam logic [7:0] SGR_BG_HI  = 8'd47;
	localparam logic [7:0] SGR_BG_DEF = 8'd49;

	localparam logic CFG_DEF_FG = 1'b0;
	localparam logic CFG_DEF_BG = 1'b1;

	localparam logic [CLR_W-1:0] RST_FG = 4'd8;
	localparam logic [CLR_W-1:0] RST_BG = 4'd0;

	typedef enum logic {
		ST_IDLE,
		ST_SGR
	} atce_state_t;

	typedef struct packed {
		logic step;
		logic sgr_start;
		logic sgr_apply;
		logic sgr_done;
	} atce_cmd_t;

	typedef struct packed {
		logic out_free;
		logic is_sgr;
		logic sgr_last;
	} atce_status_t;

endpackage

// ===== design/ansi_text_console_engine_core.sv =====
// ----------------------------------------------------------------------------
// ansi_text_console_engine_core: VT100-style text console engine
// Interprets a character stream into cell writes, line flushes, scroll
// requests and cursor moves, with a subset of ESC [ sequences.
// ----------------------------------------------------------------------------
// Each character byte enters on the input channel (in_valid, in_ready,
// char_in) and yields exactly one result item on the output channel
// (out_valid, out_ready and the result fields), in order.
// For most items the result is registered and appears on the
// cycle after acceptance. The final byte of a color sequence (m) walks the
// escape parameter file one entry per cycle, and only then is the result
// of such an item registered.
// The result register is a single slot: a new item is accepted while the
// held result is taken in the same cycle, and a stalled receiver holds the
// result and blocks further input until out_ready rises.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// is always ready; index 0 sets the default foreground and index 1 the
// default background, and writes belong to idle periods only.
// Reset puts the cursor home, closes any sequence, clears the parameters,
// restores colors 8 and 0 and empties the result register.
// ----------------------------------------------------------------------------
module ansi_text_console_engine_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [atce_pkg::CH_W-1:0]  char_in,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [atce_pkg::CLR_W-1:0] cfg_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       write_valid,
	output logic [atce_pkg::ROW_W-1:0] write_row,
	output logic [atce_pkg::COL_W-1:0] write_col,
	output logic [atce_pkg::CH_W-1:0]  write_char,
	output logic [atce_pkg::CLR_W-1:0] write_fg,
	output logic [atce_pkg::CLR_W-1:0] write_bg,
	output logic                       line_flush,
	output logic [atce_pkg::ROW_W-1:0] flush_row,
	output logic                       scroll_up,
	output logic [atce_pkg::COL_W-1:0] cursor_col_out,
	output logic [atce_pkg::ROW_W-1:0] cursor_row_out
);

	atce_pkg::atce_cmd_t    cmd;
	atce_pkg::atce_status_t status;

	assign cfg_ready = 1'b1;

	atce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	atce_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.char_in        (char_in),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_valid    (write_valid),
		.write_row      (write_row),
		.write_col      (write_col),
		.write_char     (write_char),
		.write_fg       (write_fg),
		.write_bg       (write_bg),
		.line_flush     (line_flush),
		.flush_row      (flush_row),
		.scroll_up      (scroll_up),
		.cursor_col_out (cursor_col_out),
		.cursor_row_out (cursor_row_out)
	);

endmodule

// ===== design/atce_ctrl.sv =====
// ----------------------------------------------------------------------------
// atce_ctrl: sequencing controller of the console engine
// Accepts items, issues single-cycle steps and walks the color parameter
// list one entry per cycle for a select-graphic-rendition sequence.
// ----------------------------------------------------------------------------
module atce_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  atce_pkg::atce_status_t status,
	output atce_pkg::atce_cmd_t    cmd
);

	atce_pkg::atce_state_t state_q;
	atce_pkg::atce_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atce_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			atce_pkg::ST_IDLE: begin
				in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					if (status.is_sgr) begin
						cmd.sgr_start = 1'b1;
						state_d       = atce_pkg::ST_SGR;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			atce_pkg::ST_SGR: begin
				cmd.sgr_apply = 1'b1;
				if (status.sgr_last) begin
					cmd.sgr_done = 1'b1;
					state_d      = atce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = atce_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/atce_datapath.sv =====
// ----------------------------------------------------------------------------
// atce_datapath: cursor, color and escape state with the result register
// Holds the terminal state, the escape parameter file and the color
// defaults, and forms one registered result per item.
// ----------------------------------------------------------------------------
module atce_datapath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  atce_pkg::atce_cmd_t                      cmd,
	output atce_pkg::atce_status_t                   status,
	input  logic [atce_pkg::CH_W-1:0]                char_in,
	input  logic                                     cfg_valid,
	input  logic                                     cfg_index,
	input  logic [atce_pkg::CLR_W-1:0]               cfg_data,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     write_valid,
	output logic [atce_pkg::ROW_W-1:0]               write_row,
	output logic [atce_pkg::COL_W-1:0]               write_col,
	output logic [atce_pkg::CH_W-1:0]                write_char,
	output logic [atce_pkg::CLR_W-1:0]               write_fg,
	output logic [atce_pkg::CLR_W-1:0]               write_bg,
	output logic                                     line_flush,
	output logic [atce_pkg::ROW_W-1:0]               flush_row,
	output logic                                     scroll_up,
	output logic [atce_pkg::COL_W-1:0]               cursor_col_out,
	output logic [atce_pkg::ROW_W-1:0]               cursor_row_out
);

	localparam logic [atce_pkg::COL_W-1:0] COL_MAX = atce_pkg::COL_W'(atce_pkg::COLUMNS - 1);
	localparam logic [atce_pkg::COL_W-1:0] COL_END = atce_pkg::COL_W'(atce_pkg::COLUMNS);
	localparam logic [atce_pkg::ROW_W-1:0] ROW_MAX = atce_pkg::ROW_W'(atce_pkg::ROWS - 1);
	localparam logic [atce_pkg::PIDX_W-1:0] PIDX_MAX =
		atce_pkg::PIDX_W'(atce_pkg::MAX_PARAMS - 1);

	logic [atce_pkg::CLR_W-1:0]  def_fg_q, def_bg_q;
	logic [atce_pkg::CLR_W-1:0]  cur_fg_q, cur_bg_q;
	logic [atce_pkg::COL_W-1:0]  col_q;
	logic [atce_pkg::ROW_W-1:0]  row_q;
	logic                        esc_q;
	logic [7:0]                  params_q [atce_pkg::MAX_PARAMS];
	logic [atce_pkg::PIDX_W-1:0] pidx_q;
	logic [atce_pkg::PIDX_W-1:0] sgr_idx_q;

	logic                        out_valid_q;
	logic                        wv_q, lf_q, su_q;
	logic [atce_pkg::ROW_W-1:0]  wr_q, fr_q, crow_q;
	logic [atce_pkg::COL_W-1:0]  wc_q, ccol_q;
	logic [atce_pkg::CH_W-1:0]   wch_q;
	logic [atce_pkg::CLR_W-1:0]  wf_q, wb_q;

	logic [atce_pkg::COL_W-1:0]  col_d;
	logic [atce_pkg::ROW_W-1:0]  row_d;
	logic                        esc_d;
	logic [atce_pkg::PIDX_W-1:0] pidx_d;
	logic                        clr_params;
	logic                        wr_param;
	logic [7:0]                  param_new;
	logic                        wv_d, lf_d, su_d;
	logic [atce_pkg::ROW_W-1:0]  wr_d, fr_d;
	logic [atce_pkg::COL_W-1:0]  wc_d;

	logic [atce_pkg::PIDX_W-1:0] rd_addr;
	logic [7:0]                  p_rd;
	logic [7:0]                  p0, p1;
	logic [7:0]                  digit;
	logic [atce_pkg::ROW_W:0]    row_inc;
	logic [8:0]                  row_sum, col_sum;
	logic [atce_pkg::ROW_W-1:0]  prow;
	logic [atce_pkg::COL_W-1:0]  pcol;
	logic [atce_pkg::CLR_W-1:0]  sgr_fg, sgr_bg;

	assign rd_addr = cmd.sgr_apply ? sgr_idx_q : pidx_q;
	assign p_rd    = params_q[rd_addr];
	assign p0      = params_q[0];
	assign p1      = params_q[1];
	assign digit   = char_in - atce_pkg::CH_ZERO;
	assign param_new = 8'((p_rd << 3) + (p_rd << 1) + digit);
	assign row_inc = {1'b0, row_q} + 1'b1;
	assign row_sum = {4'b0, row_q} + {1'b0, p0};
	assign col_sum = {2'b0, col_q} + {1'b0, p0};
	assign prow = (p1 > 8'(ROW_MAX)) ? ROW_MAX : p1[atce_pkg::ROW_W-1:0];
	assign pcol = (p0 > 8'(COL_MAX)) ? COL_MAX : p0[atce_pkg::COL_W-1:0];

	assign status.out_free = !out_valid_q || out_ready;
	assign status.is_sgr   = esc_q && (char_in == atce_pkg::CH_SGR);
	assign status.sgr_last = (sgr_idx_q == pidx_q);

	always_comb begin
		col_d      = col_q;
		row_d      = row_q;
		esc_d      = esc_q;
		pidx_d     = pidx_q;
		clr_params = 1'b0;
		wr_param   = 1'b0;
		wv_d       = 1'b0;
		wr_d       = '0;
		wc_d       = '0;
		lf_d       = 1'b0;
		fr_d       = '0;
		su_d       = 1'b0;
		if (char_in == atce_pkg::CH_NUL) begin
			col_d = col_q;
		end else if (char_in == atce_pkg::CH_BS) begin
			if (col_q != '0) begin
				col_d = col_q - 1'b1;
			end
		end else if (char_in == atce_pkg::CH_CR) begin
			lf_d  = 1'b1;
			fr_d  = row_q;
			col_d = '0;
		end else if (char_in == atce_pkg::CH_LF) begin
			lf_d  = 1'b1;
			fr_d  = row_q;
			col_d = '0;
			if (row_q >= ROW_MAX) begin
				su_d  = 1'b1;
				row_d = ROW_MAX;
			end else begin
				row_d = row_inc[atce_pkg::ROW_W-1:0];
			end
		end else if (char_in == atce_pkg::CH_ESC) begin
			esc_d      = 1'b1;
			pidx_d     = '0;
			clr_params = 1'b1;
		end else if (esc_q) begin
			if (char_in >= atce_pkg::CH_ZERO && char_in <= atce_pkg::CH_NINE) begin
				wr_param = 1'b1;
			end else if (char_in == atce_pkg::CH_LBRK) begin
				esc_d = 1'b1;
			end else if (char_in == atce_pkg::CH_SEMI) begin
				pidx_d = (pidx_q == PIDX_MAX) ? '0 : pidx_q + 1'b1;
			end else begin
				esc_d = 1'b0;
				case (char_in)
					atce_pkg::CH_CUP_H: begin
						if (pidx_q == '0) begin
							col_d = '0;
							row_d = '0;
						end else begin
							col_d = pcol;
							row_d = prow;
						end
					end
					atce_pkg::CH_CUP_F: begin
						col_d = pcol;
						row_d = prow;
					end
					atce_pkg::CH_CUU: begin
						row_d = (p0 >= {3'b0, row_q}) ? '0 :
							row_q - p0[atce_pkg::ROW_W-1:0];
					end
					atce_pkg::CH_CUD: begin
						row_d = (row_sum > 9'(ROW_MAX)) ? ROW_MAX :
							row_sum[atce_pkg::ROW_W-1:0];
					end
					atce_pkg::CH_CUF: begin
						col_d = (col_sum > 9'(COL_MAX)) ? COL_MAX :
							col_sum[atce_pkg::COL_W-1:0];
					end
					atce_pkg::CH_CUB: begin
						col_d = (p0 >= {1'b0, col_q}) ? '0 :
							col_q - p0[atce_pkg::COL_W-1:0];
					end
					atce_pkg::CH_CHA: begin
						col_d = pcol;
					end
					default: begin
						col_d = col_q;
					end
				endcase
			end
		end else begin
			wv_d = 1'b1;
			if (col_q >= COL_END) begin
				lf_d = 1'b1;
				fr_d = row_q;
				if (row_q >= ROW_MAX) begin
					su_d = 1'b1;
					wr_d = ROW_MAX;
				end else begin
					wr_d = row_inc[atce_pkg::ROW_W-1:0];
				end
				wc_d = '0;
			end else begin
				wr_d = row_q;
				wc_d = col_q;
			end
			row_d = wr_d;
			col_d = wc_d + 1'b1;
		end
	end

	always_comb begin
		sgr_fg = cur_fg_q;
		sgr_bg = cur_bg_q;
		if (p_rd == atce_pkg::SGR_RESET) begin
			sgr_fg = def_fg_q;
			sgr_bg = def_bg_q;
		end else if (p_rd == atce_pkg::SGR_FG_DEF) begin
			sgr_fg = def_fg_q;
		end else if (p_rd == atce_pkg::SGR_BG_DEF) begin
			sgr_bg = def_bg_q;
		end else if (p_rd >= atce_pkg::SGR_FG_LO && p_rd <= atce_pkg::SGR_FG_HI) begin
			sgr_fg = atce_pkg::CLR_W'(p_rd - atce_pkg::SGR_FG_LO);
		end else if (p_rd >= atce_pkg::SGR_BG_LO && p_rd <= atce_pkg::SGR_BG_HI) begin
			sgr_bg = atce_pkg::CLR_W'(p_rd - atce_pkg::SGR_BG_LO);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_fg_q  <= atce_pkg::RST_FG;
			def_bg_q  <= atce_pkg::RST_BG;
			cur_fg_q  <= atce_pkg::RST_FG;
			cur_bg_q  <= atce_pkg::RST_BG;
			col_q     <= '0;
			row_q     <= '0;
			esc_q     <= 1'b0;
			pidx_q    <= '0;
			sgr_idx_q <= '0;
			for (int i = 0; i < atce_pkg::MAX_PARAMS; i++) begin
				params_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				if (cfg_index == atce_pkg::CFG_DEF_FG) begin
					def_fg_q <= cfg_data;
				end else begin
					def_bg_q <= cfg_data;
				end
			end
			if (cmd.step) begin
				col_q  <= col_d;
				row_q  <= row_d;
				esc_q  <= esc_d;
				pidx_q <= pidx_d;
				if (clr_params) begin
					for (int i = 0; i < atce_pkg::MAX_PARAMS; i++) begin
						params_q[i] <= '0;
					end
				end else if (wr_param) begin
					params_q[pidx_q] <= param_new;
				end
			end
			if (cmd.sgr_start) begin
				esc_q     <= 1'b0;
				sgr_idx_q <= '0;
			end
			if (cmd.sgr_apply) begin
				cur_fg_q  <= sgr_fg;
				cur_bg_q  <= sgr_bg;
				sgr_idx_q <= sgr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step || cmd.sgr_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			wv_q   <= wv_d;
			wr_q   <= wr_d & {atce_pkg::ROW_W{wv_d}};
			wc_q   <= wc_d;
			wch_q  <= wv_d ? char_in : '0;
			wf_q   <= wv_d ? cur_fg_q : '0;
			wb_q   <= wv_d ? cur_bg_q : '0;
			lf_q   <= lf_d;
			fr_q   <= fr_d;
			su_q   <= su_d;
			ccol_q <= col_d;
			crow_q <= row_d;
		end else if (cmd.sgr_done) begin
			wv_q   <= 1'b0;
			wr_q   <= '0;
			wc_q   <= '0;
			wch_q  <= '0;
			wf_q   <= '0;
			wb_q   <= '0;
			lf_q   <= 1'b0;
			fr_q   <= '0;
			su_q   <= 1'b0;
			ccol_q <= col_q;
			crow_q <= row_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign write_valid    = wv_q;
	assign write_row      = wr_q;
	assign write_col      = wc_q;
	assign write_char     = wch_q;
	assign write_fg       = wf_q;
	assign write_bg       = wb_q;
	assign line_flush     = lf_q;
	assign flush_row      = fr_q;
	assign scroll_up      = su_q;
	assign cursor_col_out = ccol_q;
	assign cursor_row_out = crow_q;

endmodule
